// ----- sv/kps_pkg.sv -----
package kps_pkg;

   // default matrix geometry
   localparam int ROWS_DEF = 4;
   localparam int COLS_DEF = 5;

   // field widths
   localparam int ACTION_W  = 2;
   localparam int COLUMNS_W = 5;
   localparam int DIGIT_W   = 2;
   localparam int HEX_W     = 4;
   localparam int SEG_W     = 8;
   localparam int SCAN_W    = 5;
   localparam int KEYVAL_W  = 8;
   localparam int PERIOD_W  = 16;
   localparam int TIMER_W   = 20;
   localparam int KEY_CODE_W = 6;
   localparam int DIGITS    = 4;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [PERIOD_W-1:0] PERIOD_RST   = 16'd3000;
   localparam logic [TIMER_W-1:0]  DELAY_RST    = 20'd1000000;
   localparam logic [TIMER_W-1:0]  INTERVAL_RST = 20'd150000;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_EVENT  = 1'b1;

   localparam logic DP_BIT_SET   = 1'b1;
   localparam logic [SEG_W-1:0] DP_MASK = 8'h01;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCAN_PERIOD     = 2'd0,
      CSR_REPEAT_DELAY    = 2'd1,
      CSR_REPEAT_INTERVAL = 2'd2
   } kps_csr_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK = 2'd0,
      ACT_RAW  = 2'd1,
      ACT_HEX  = 2'd2,
      ACT_DP   = 2'd3
   } kps_action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STATUS,
      ST_WALK,
      ST_REPEAT,
      ST_FLUSH
   } kps_state_type;

   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [COLUMNS_W-1:0] columns;
      logic [DIGIT_W-1:0]   digit_index;
      logic [HEX_W-1:0]     hex_value;
      logic [SEG_W-1:0]     pattern;
      logic                 dp_on;
   } kps_item_type;

   typedef struct packed {
      logic                kind;
      logic [SEG_W-1:0]    segments;
      logic [DIGIT_W-1:0]  digit_select;
      logic [SCAN_W-1:0]   scancode;
      logic [KEYVAL_W-1:0] key_value;
      logic                pressed;
      logic                is_repeat;
   } kps_result_type;

   // controller to datapath
   typedef struct packed {
      logic exec;
      logic gen_status;
      logic gen_event;
      logic walk_step;
      logic gen_repeat;
      logic finish_frame;
      logic push_last;
   } kps_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic frame_end;
      logic key_changed;
      logic key_final;
      logic repeat_due;
      logic stg_valid;
      logic rsp_free;
   } kps_sts_type;

   localparam logic [SEG_W-1:0] HEX_FONT [16] = '{
      8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
      8'hFE, 8'hF6, 8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E
   };

   // scancodes twenty and up map to zero
   localparam logic [KEYVAL_W-1:0] KEY_TABLE [32] = '{
      8'h83, 8'h0F, 8'h0E, 8'h0D, 8'h0C, 8'h82, 8'h0B, 8'h0A,
      8'h09, 8'h08, 8'h81, 8'h07, 8'h06, 8'h05, 8'h04, 8'h80,
      8'h03, 8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   function automatic logic [SEG_W-1:0] hex_font(input logic [HEX_W-1:0] v);
      return HEX_FONT[v];
   endfunction

   function automatic logic [KEYVAL_W-1:0] key_of(input logic [KEY_CODE_W-1:0] code);
      logic [KEYVAL_W-1:0] val;
      if (code[KEY_CODE_W-1]) begin
         val = '0;
      end else begin
         val = KEY_TABLE[code[KEY_CODE_W-2:0]];
      end
      return val;
   endfunction

endpackage

// ----- sv/kps_req_if.sv -----
interface kps_req_if;
   logic                               valid;
   logic                               ready;
   logic [kps_pkg::ACTION_W-1:0]       action;
   logic [kps_pkg::COLUMNS_W-1:0]      columns;
   logic [kps_pkg::DIGIT_W-1:0]        digit_index;
   logic [kps_pkg::HEX_W-1:0]          hex_value;
   logic [kps_pkg::SEG_W-1:0]          pattern;
   logic                               dp_on;

   modport source (
      output valid, action, columns, digit_index, hex_value, pattern, dp_on,
      input  ready
   );
   modport sink (
      input  valid, action, columns, digit_index, hex_value, pattern, dp_on,
      output ready
   );
endinterface

// ----- sv/kps_rsp_if.sv -----
interface kps_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic [kps_pkg::SEG_W-1:0]          segments;
   logic [kps_pkg::DIGIT_W-1:0]        digit_select;
   logic [kps_pkg::SCAN_W-1:0]         scancode;
   logic [kps_pkg::KEYVAL_W-1:0]       key_value;
   logic                               pressed;
   logic                               is_repeat;
   logic                               last;

   modport source (
      output valid, kind, segments, digit_select, scancode, key_value, pressed,
             is_repeat, last,
      input  ready
   );
   modport sink (
      input  valid, kind, segments, digit_select, scancode, key_value, pressed,
             is_repeat, last,
      output ready
   );
endinterface

// ----- sv/kps_ctrl.sv -----
module kps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kps_pkg::kps_sts_type sts,
   output kps_pkg::kps_cmd_type cmd
);

   kps_pkg::kps_state_type state_ff;
   kps_pkg::kps_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         kps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = kps_pkg::ST_STATUS;
            end
         end
         kps_pkg::ST_STATUS: begin
            cmd.gen_status = 1'b1;
            state_in = sts.frame_end ? kps_pkg::ST_WALK : kps_pkg::ST_FLUSH;
         end
         kps_pkg::ST_WALK: begin
            // a changed key waits until the staged beat can move on
            if (!sts.key_changed || !sts.stg_valid || sts.rsp_free) begin
               cmd.walk_step = 1'b1;
               cmd.gen_event = sts.key_changed;
               if (sts.key_final) begin
                  state_in = kps_pkg::ST_REPEAT;
               end
            end
         end
         kps_pkg::ST_REPEAT: begin
            if (!sts.repeat_due) begin
               cmd.finish_frame = 1'b1;
               state_in = kps_pkg::ST_FLUSH;
            end else if (!sts.stg_valid || sts.rsp_free) begin
               cmd.gen_repeat   = 1'b1;
               cmd.finish_frame = 1'b1;
               state_in = kps_pkg::ST_FLUSH;
            end
         end
         kps_pkg::ST_FLUSH: begin
            if (sts.rsp_free) begin
               cmd.push_last = 1'b1;
               state_in = kps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kps_pkg::ST_IDLE;
         end
      endcase
   end

   a_flush_has_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == kps_pkg::ST_FLUSH |-> sts.stg_valid)
      else $error("flush with nothing staged");

   a_walk_after_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kps_pkg::ST_STATUS && state_in == kps_pkg::ST_WALK) |-> sts.frame_end)
      else $error("key walk without frame end");

endmodule

// ----- sv/kps_datapath.sv -----
module kps_datapath #(
   parameter int ROWS = kps_pkg::ROWS_DEF,
   parameter int COLS = kps_pkg::COLS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  kps_pkg::kps_item_type               item,
   input  logic                                csr_wr_en,
   input  logic [kps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [kps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  kps_pkg::kps_cmd_type                cmd,
   output kps_pkg::kps_sts_type                sts,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output kps_pkg::kps_result_type             rsp_data,
   output logic                                rsp_last
);

   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int KEYS   = ROWS * COLS;
   localparam int CODE_W = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int PW     = kps_pkg::PERIOD_W;
   localparam int TW     = kps_pkg::TIMER_W;
   localparam int SW     = kps_pkg::SEG_W;

   // configuration
   logic [PW-1:0] period_ff, period_in;
   logic [TW-1:0] delay_cfg_ff, delay_cfg_in;
   logic [TW-1:0] interval_cfg_ff, interval_cfg_in;

   // display and scan state
   logic [SW-1:0]               digit_ff [kps_pkg::DIGITS];
   logic [SW-1:0]               digit_in [kps_pkg::DIGITS];
   logic [ROW_W-1:0]            scan_row_ff, scan_row_in;
   logic [kps_pkg::DIGIT_W-1:0] lit_ff, lit_in;
   logic [SW-1:0]               seg_ff, seg_in;
   logic [PW-1:0]               cnt_ff, cnt_in;
   logic [COLS-1:0]             old_map_ff [ROWS];
   logic [COLS-1:0]             old_map_in [ROWS];
   logic [COLS-1:0]             new_map_ff [ROWS];
   logic [COLS-1:0]             new_map_in [ROWS];
   logic                        end_ff, end_in;

   // held key and timers
   logic [kps_pkg::SCAN_W-1:0] held_key_ff, held_key_in;
   logic                       held_valid_ff, held_valid_in;
   logic [TW-1:0]              delay_ff, delay_in;
   logic [TW-1:0]              interval_ff, interval_in;

   // key walk
   logic [ROW_W-1:0]  key_row_ff, key_row_in;
   logic [COL_W-1:0]  key_col_ff, key_col_in;
   logic [CODE_W-1:0] key_code_ff, key_code_in;

   // staging and output
   logic                    stg_valid_ff, stg_valid_in;
   kps_pkg::kps_result_type stg_ff, stg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   kps_pkg::kps_result_type rsp_ff, rsp_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [ROW_W+1:0]                row_ext;
   logic [kps_pkg::DIGIT_W-1:0]     rd_idx;
   logic [SW-1:0]                   rd_pat;
   logic [PW:0]                     cnt_inc;
   logic                            scan_step;
   logic                            row_wrap;
   logic [COLS+kps_pkg::COLUMNS_W-1:0] col_ext;
   logic                            cur_new;
   logic                            cur_old;
   logic                            key_changed;
   logic                            key_final;
   logic [kps_pkg::KEY_CODE_W-1:0]  code_full;
   logic [kps_pkg::SCAN_W-1:0]      code5;
   logic                            repeat_due;
   logic                            rsp_free;
   logic                            gen_any;
   logic                            push;
   kps_pkg::kps_result_type         status_res;
   kps_pkg::kps_result_type         event_res;
   kps_pkg::kps_result_type         repeat_res;

   assign row_ext   = {2'b00, scan_row_ff};
   assign rd_idx    = (kps_pkg::kps_action_type'(item.action) == kps_pkg::ACT_DP) ?
                      item.digit_index : row_ext[kps_pkg::DIGIT_W-1:0];
   assign rd_pat    = digit_ff[rd_idx];
   assign cnt_inc   = {1'b0, cnt_ff} + (PW+1)'(1);
   assign scan_step = cnt_inc >= {1'b0, period_ff};
   assign row_wrap  = scan_row_ff == ROW_W'(ROWS - 1);
   assign col_ext   = {{COLS{1'b0}}, item.columns};

   assign cur_new     = new_map_ff[key_row_ff][key_col_ff];
   assign cur_old     = old_map_ff[key_row_ff][key_col_ff];
   assign key_changed = cur_new ^ cur_old;
   assign key_final   = key_code_ff == CODE_W'(KEYS - 1);
   assign code_full   = kps_pkg::KEY_CODE_W'(key_code_ff);
   assign code5       = code_full[kps_pkg::SCAN_W-1:0];
   assign repeat_due  = held_valid_ff && (delay_ff == '0) && (interval_ff == '0);

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign gen_any  = cmd.gen_status || cmd.gen_event || cmd.gen_repeat;
   // a new beat pushes the staged one out; only the flush marks it last
   assign push     = (gen_any && stg_valid_ff) || cmd.push_last;

   always_comb begin
      status_res              = '0;
      status_res.kind         = kps_pkg::KIND_STATUS;
      status_res.segments     = seg_ff;
      status_res.digit_select = lit_ff;

      event_res              = '0;
      event_res.kind         = kps_pkg::KIND_EVENT;
      event_res.segments     = seg_ff;
      event_res.digit_select = lit_ff;
      event_res.scancode     = code5;
      event_res.key_value    = kps_pkg::key_of(code_full);
      event_res.pressed      = cur_new;

      repeat_res              = '0;
      repeat_res.kind         = kps_pkg::KIND_EVENT;
      repeat_res.segments     = seg_ff;
      repeat_res.digit_select = lit_ff;
      repeat_res.scancode     = held_key_ff;
      repeat_res.key_value    = kps_pkg::key_of({1'b0, held_key_ff});
      repeat_res.pressed      = 1'b1;
      repeat_res.is_repeat    = 1'b1;
   end

   always_comb begin
      period_in       = period_ff;
      delay_cfg_in    = delay_cfg_ff;
      interval_cfg_in = interval_cfg_ff;
      digit_in        = digit_ff;
      scan_row_in     = scan_row_ff;
      lit_in          = lit_ff;
      seg_in          = seg_ff;
      cnt_in          = cnt_ff;
      old_map_in      = old_map_ff;
      new_map_in      = new_map_ff;
      end_in          = end_ff;
      held_key_in     = held_key_ff;
      held_valid_in   = held_valid_ff;
      delay_in        = delay_ff;
      interval_in     = interval_ff;
      key_row_in      = key_row_ff;
      key_col_in      = key_col_ff;
      key_code_in     = key_code_ff;
      stg_valid_in    = stg_valid_ff;
      stg_in          = stg_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_in          = rsp_ff;
      rsp_last_in     = rsp_last_ff;

      if (csr_wr_en) begin
         unique case (kps_pkg::kps_csr_type'(csr_index))
            kps_pkg::CSR_SCAN_PERIOD:     period_in       = csr_wdata[PW-1:0];
            kps_pkg::CSR_REPEAT_DELAY:    delay_cfg_in    = csr_wdata[TW-1:0];
            kps_pkg::CSR_REPEAT_INTERVAL: interval_cfg_in = csr_wdata[TW-1:0];
            default: ;
         endcase
      end

      if (cmd.exec) begin
         end_in = 1'b0;
         unique case (kps_pkg::kps_action_type'(item.action))
            kps_pkg::ACT_RAW: digit_in[item.digit_index] = item.pattern;
            kps_pkg::ACT_HEX: digit_in[item.digit_index] = kps_pkg::hex_font(item.hex_value);
            kps_pkg::ACT_DP: begin
               if (item.dp_on == kps_pkg::DP_BIT_SET) begin
                  digit_in[item.digit_index] = rd_pat | kps_pkg::DP_MASK;
               end else begin
                  digit_in[item.digit_index] = rd_pat & ~kps_pkg::DP_MASK;
               end
            end
            kps_pkg::ACT_TICK: begin
               if (delay_ff != '0) delay_in = delay_ff - TW'(1);
               if (interval_ff != '0) interval_in = interval_ff - TW'(1);
               cnt_in = cnt_inc[PW-1:0];
               if (scan_step) begin
                  cnt_in                  = '0;
                  lit_in                  = row_ext[kps_pkg::DIGIT_W-1:0];
                  seg_in                  = rd_pat;
                  new_map_in[scan_row_ff] = col_ext[COLS-1:0];
                  scan_row_in             = row_wrap ? '0 : scan_row_ff + ROW_W'(1);
                  end_in                  = row_wrap;
               end
            end
            default: ;
         endcase
      end

      if (cmd.gen_status) begin
         key_row_in  = '0;
         key_col_in  = '0;
         key_code_in = '0;
      end

      if (cmd.walk_step) begin
         key_code_in = key_code_ff + CODE_W'(1);
         if (key_col_ff == COL_W'(COLS - 1)) begin
            key_col_in = '0;
            key_row_in = key_row_ff + ROW_W'(1);
         end else begin
            key_col_in = key_col_ff + COL_W'(1);
         end
      end

      if (cmd.gen_event) begin
         if (!held_valid_ff) begin
            if (cur_new) begin
               held_key_in   = code5;
               held_valid_in = 1'b1;
               delay_in      = delay_cfg_ff;
            end
         end else if (!cur_new && held_key_ff == code5) begin
            held_valid_in = 1'b0;
         end
      end

      if (cmd.gen_repeat) begin
         interval_in = interval_cfg_ff;
      end

      if (cmd.finish_frame) begin
         old_map_in = new_map_ff;
      end

      // output register: take the staged beat, or drop the one taken
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_in       = stg_ff;
         rsp_last_in  = cmd.push_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.push_last) begin
         stg_valid_in = 1'b0;
      end
      if (gen_any) begin
         stg_valid_in = 1'b1;
         priority if (cmd.gen_status) begin
            stg_in = status_res;
         end else if (cmd.gen_event) begin
            stg_in = event_res;
         end else begin
            stg_in = repeat_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= kps_pkg::PERIOD_RST;
         delay_cfg_ff    <= kps_pkg::DELAY_RST;
         interval_cfg_ff <= kps_pkg::INTERVAL_RST;
         for (int i = 0; i < kps_pkg::DIGITS; i++) begin
            digit_ff[i] <= '0;
         end
         scan_row_ff <= '0;
         lit_ff      <= '0;
         seg_ff      <= '0;
         cnt_ff      <= '0;
         for (int r = 0; r < ROWS; r++) begin
            old_map_ff[r] <= '0;
            new_map_ff[r] <= '0;
         end
         end_ff        <= 1'b0;
         held_key_ff   <= '0;
         held_valid_ff <= 1'b0;
         delay_ff      <= '0;
         interval_ff   <= '0;
         key_row_ff    <= '0;
         key_col_ff    <= '0;
         key_code_ff   <= '0;
         stg_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         period_ff       <= period_in;
         delay_cfg_ff    <= delay_cfg_in;
         interval_cfg_ff <= interval_cfg_in;
         digit_ff        <= digit_in;
         scan_row_ff     <= scan_row_in;
         lit_ff          <= lit_in;
         seg_ff          <= seg_in;
         cnt_ff          <= cnt_in;
         old_map_ff      <= old_map_in;
         new_map_ff      <= new_map_in;
         end_ff          <= end_in;
         held_key_ff     <= held_key_in;
         held_valid_ff   <= held_valid_in;
         delay_ff        <= delay_in;
         interval_ff     <= interval_in;
         key_row_ff      <= key_row_in;
         key_col_ff      <= key_col_in;
         key_code_ff     <= key_code_in;
         stg_valid_ff    <= stg_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_last_ff     <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_ff <= stg_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      sts.frame_end   = end_ff;
      sts.key_changed = key_changed;
      sts.key_final   = key_final;
      sts.repeat_due  = repeat_due;
      sts.stg_valid   = stg_valid_ff;
      sts.rsp_free    = rsp_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_last  = rsp_last_ff;

   a_push_when_free: assert property (@(posedge clock) disable iff (reset)
      push |-> rsp_free)
      else $error("output beat overwritten");

   a_status_on_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.gen_status |-> !stg_valid_ff && !end_ff || cmd.gen_status && !stg_valid_ff)
      else $error("status generated over a staged beat");

   a_flush_moves: assert property (@(posedge clock) disable iff (reset)
      cmd.push_last |=> rsp_valid_ff && rsp_last_ff && !stg_valid_ff)
      else $error("final beat lost");

   a_walk_code: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> 32'(key_code_ff) == 32'(key_row_ff) * COLS + 32'(key_col_ff))
      else $error("key walk pointer out of step");

endmodule

// ----- sv/display_keypad_scanner.sv -----
// channel   | dir | handshake          | beat
// req_chan  | in  | valid/ready        | action, columns, digit_index, hex_value, pattern, dp_on
// rsp_chan  | out | valid/ready        | kind, segments, digit_select, scancode, key_value,
//           |     |                    | pressed, is_repeat, last
// csr_*     | in  | csr_wr_en, no wait | csr_index selects the register, csr_wdata the value
//
// One item at a time: a write or a tick passes the states accept, status and flush.
// A tick that ends a frame walks every key of the ROWS x COLS matrix after status and
// then runs the repeat check before the flush.
// Every result passes a staging register and an output register; while the output side
// stalls, a beat that waits holds the walk, the repeat check or the flush in place.
// Synchronous reset sets all but the staged and output beat data at once; no clearing pass.
module display_keypad_scanner #(
   parameter int ROWS = kps_pkg::ROWS_DEF,
   parameter int COLS = kps_pkg::COLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   kps_req_if.sink                        req_chan,
   kps_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [kps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kps_pkg::CSR_DATA_W-1:0] csr_wdata
);

   kps_pkg::kps_cmd_type    cmd;
   kps_pkg::kps_sts_type    sts;
   kps_pkg::kps_item_type   item;
   kps_pkg::kps_result_type rsp_data;
   logic                    req_ready;
   logic                    rsp_valid;
   logic                    rsp_last;

   always_comb begin
      item.action      = req_chan.action;
      item.columns     = req_chan.columns;
      item.digit_index = req_chan.digit_index;
      item.hex_value   = req_chan.hex_value;
      item.pattern     = req_chan.pattern;
      item.dp_on       = req_chan.dp_on;
   end

   assign req_chan.ready = req_ready;

   kps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kps_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_last  (rsp_last)
   );

   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.kind         = rsp_data.kind;
   assign rsp_chan.segments     = rsp_data.segments;
   assign rsp_chan.digit_select = rsp_data.digit_select;
   assign rsp_chan.scancode     = rsp_data.scancode;
   assign rsp_chan.key_value    = rsp_data.key_value;
   assign rsp_chan.pressed      = rsp_data.pressed;
   assign rsp_chan.is_repeat    = rsp_data.is_repeat;
   assign rsp_chan.last         = rsp_last;

endmodule
